// File: hdl/gauss_seidel_solver_unit_macros.svh
// Assertion helpers shared by the solver RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef GAUSS_SEIDEL_SOLVER_UNIT_MACROS_SVH
`define GAUSS_SEIDEL_SOLVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GSS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gss: same-cycle check failed");

// Next-cycle implication.
`define GSS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gss: next-cycle check failed");

`endif

// File: hdl/gss_pkg.sv
package gss_pkg;

  localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] CMD_LOAD_RHS    = 2'd1;
  localparam logic [1:0] CMD_SOLVE       = 2'd2;

  localparam logic [1:0] STATUS_CONVERGED  = 2'd0;
  localparam logic [1:0] STATUS_ITER_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PIVOT = 2'd2;

  localparam logic [1:0] CFG_SYSTEM_SIZE     = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE       = 2'd1;
  localparam logic [1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam int CfgWidth = 16;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         solution_index;
    logic signed [31:0] solution_value;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

// File: hdl/gss_ram.sv
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gauss_seidel_solver_unit.sv
// Gauss-Seidel solver for A*x = y in signed fixed point (FRACTION_BITS fraction bits).
// Input: command transactions on cmd_i, taken when start_i is high and busy_o is low.
//   Load commands write one element of A or y; busy_o stays low.
//   A solve command raises busy_o until its last result has been presented.
// Config: cfg_we_i/cfg_idx_i/cfg_wdata_i write size, tolerance and sweep limit; write
//   only while busy_o is low.
// Output: one result per unknown on res_o, each present for exactly one cycle with
//   res_valid_o high; the receiver cannot stall, so results are never held back.
// Solve steps: diagonal scan, scaling (per row one offset divide and one divide per
//   coefficient), sweeps until converged or the limit is reached, then emission.
//   A zero diagonal skips scaling and sweeps.
//   The pace is set by one shared restoring divider (one quotient bit per cycle)
//   and one shared multiply-accumulate that reads, multiplies and adds each term.
// Reset: config returns to size 8, tolerance 655, limit 1000; block goes idle.
//   A and y are undefined until loaded.
`include "gauss_seidel_solver_unit_macros.svh"

module gauss_seidel_solver_unit #(
  parameter int MAX_UNKNOWNS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  gss_pkg::cmd_t                 cmd_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [gss_pkg::CfgWidth-1:0]  cfg_wdata_i,
  output logic                          res_valid_o,
  output gss_pkg::res_t                 res_o
);

  localparam int IW    = $clog2(MAX_UNKNOWNS);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NMAX  = (MAX_UNKNOWNS < 8) ? MAX_UNKNOWNS : 8;
  localparam int CW    = (IW > 4) ? IW : 4;
  localparam int DW    = 32 + FRACTION_BITS;
  localparam int DCW   = $clog2(DW);

  localparam logic [DW-1:0] QPosMax = DW'(64'h7FFF_FFFF);
  localparam logic [DW-1:0] QNegMax = DW'(64'h8000_0000);

  // Sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DIAG_RD   = 5'd1;
  localparam logic [4:0] S_DIAG_CHK  = 5'd2;
  localparam logic [4:0] S_PIV_RD    = 5'd3;
  localparam logic [4:0] S_PIV_LD    = 5'd4;
  localparam logic [4:0] S_DIV       = 5'd5;
  localparam logic [4:0] S_DIV_DONE  = 5'd6;
  localparam logic [4:0] S_COEF_RD   = 5'd7;
  localparam logic [4:0] S_COEF_LD   = 5'd8;
  localparam logic [4:0] S_ROW_INIT  = 5'd9;
  localparam logic [4:0] S_TERM_RD   = 5'd10;
  localparam logic [4:0] S_TERM_MUL  = 5'd11;
  localparam logic [4:0] S_TERM_ACC  = 5'd12;
  localparam logic [4:0] S_ROW_END   = 5'd13;
  localparam logic [4:0] S_SWEEP_END = 5'd14;
  localparam logic [4:0] S_EMIT      = 5'd15;

  // Config registers
  logic [3:0]  size_q;
  logic [15:0] tol_q, limit_q;

  // Control
  logic [4:0]     state_q, state_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d;
  logic [3:0]     n_last_q, n_last_d;
  logic [15:0]    limit_eff_q, limit_eff_d;
  logic [15:0]    sweep_cnt_q, sweep_cnt_d;
  logic           changed_q, changed_d;
  logic           zero_q, zero_d;
  logic [1:0]     status_q, status_d;
  logic           div_coef_q, div_coef_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;
  logic           res_valid_q, res_valid_d;

  // Payload
  gss_pkg::res_t      res_q, res_d;
  logic signed [31:0] x_q [MAX_UNKNOWNS];
  logic signed [31:0] rhs_q [MAX_UNKNOWNS];
  logic signed [31:0] dvec_q [MAX_UNKNOWNS];
  logic signed [31:0] piv_q;
  logic signed [63:0] prod_q, acc_q;
  logic [DW-1:0]      div_quo_q;
  logic [31:0]        div_rem_q, div_den_q;
  logic               div_neg_q;

  // Memories
  logic [AW-1:0] mat_waddr, rd_addr;
  logic          mat_we, coef_we;
  logic [31:0]   mat_rdata, coef_rdata;

  // Helpers
  logic               last_i, last_j, j_is_i, solve_go, load_go;
  logic [IW-1:0]      x_idx;
  logic signed [31:0] x_rd, q_sat, nx;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [32:0] div_num;
  logic signed [31:0] div_den_in;
  logic               div_start;
  logic signed [63:0] acc_sum;
  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic [3:0]         n_eff;

  assign solve_go = start_i && !busy_o && (cmd_i.command == gss_pkg::CMD_SOLVE);
  assign load_go  = start_i && !busy_o;
  assign last_i   = CW'(i_q) == CW'(n_last_q);
  assign last_j   = CW'(j_q) == CW'(n_last_q);
  assign j_is_i   = (j_q == i_q);

  assign x_idx = (state_q == S_TERM_MUL) ? j_q : i_q;
  assign x_rd  = x_q[x_idx];

  // Matrix store: loads write, the solve reads one element at a time (registered read)
  assign mat_we = load_go && (cmd_i.command == gss_pkg::CMD_LOAD_MATRIX)
               && (int'(cmd_i.row_index) < MAX_UNKNOWNS)
               && (int'(cmd_i.col_index) < MAX_UNKNOWNS);
  assign mat_waddr = {IW'(cmd_i.row_index), IW'(cmd_i.col_index)};
  assign rd_addr   = ((state_q == S_DIAG_RD) || (state_q == S_PIV_RD)) ? {i_q, i_q}
                                                                      : {i_q, j_q};
  assign coef_we   = (state_q == S_DIV_DONE) && div_coef_q;

  gss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (cmd_i.value),
    .raddr_i (rd_addr),
    .rdata_o (mat_rdata)
  );

  gss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i ({i_q, j_q}),
    .wdata_i (q_sat),
    .raddr_i (rd_addr),
    .rdata_o (coef_rdata)
  );

  // Divider operands: y[i]/a[i][i] for the offset, -a[i][j]/a[i][i] for coefficients
  assign div_start  = (state_q == S_PIV_LD) || (state_q == S_COEF_LD);
  assign div_num    = (state_q == S_PIV_LD) ? 33'(rhs_q[i_q])
                                            : -(33'(signed'(mat_rdata)));
  assign div_den_in = (state_q == S_PIV_LD) ? signed'(mat_rdata) : piv_q;

  // Restoring divide step: one quotient bit per cycle
  assign rem_sh = {div_rem_q, div_quo_q[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};

  // Sign and saturate the quotient magnitude
  always_comb begin
    if (!div_neg_q) begin
      q_sat = (div_quo_q > QPosMax) ? 32'sh7FFF_FFFF : signed'(div_quo_q[31:0]);
    end else begin
      q_sat = (div_quo_q > QNegMax) ? 32'sh8000_0000 : signed'(32'd0 - div_quo_q[31:0]);
    end
  end

  // Row sum saturation and change against the previous component
  assign acc_sum = acc_q;
  always_comb begin
    if (acc_sum > 64'sh0000_0000_7FFF_FFFF) begin
      nx = 32'sh7FFF_FFFF;
    end else if (acc_sum < -64'sh0000_0000_8000_0000) begin
      nx = 32'sh8000_0000;
    end else begin
      nx = acc_sum[31:0];
    end
  end
  assign diff     = 33'(nx) - 33'(x_rd);
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

  // Effective size: zero acts as one, clamp to the storage and to at most 8
  always_comb begin
    if (size_q == 4'd0) begin
      n_eff = 4'd1;
    end else if (int'(size_q) > NMAX) begin
      n_eff = 4'(NMAX);
    end else begin
      n_eff = size_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_last_d    = n_last_q;
    limit_eff_d = limit_eff_q;
    sweep_cnt_d = sweep_cnt_q;
    changed_d   = changed_q;
    zero_d      = zero_q;
    status_d    = status_q;
    div_coef_d  = div_coef_q;
    div_cnt_d   = div_cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        if (solve_go) begin
          n_last_d    = n_eff - 4'd1;
          limit_eff_d = (limit_q == 16'd0) ? 16'd1 : limit_q;
          sweep_cnt_d = '0;
          changed_d   = 1'b0;
          zero_d      = 1'b0;
          i_d         = '0;
          state_d     = S_DIAG_RD;
        end
      end
      S_DIAG_RD: state_d = S_DIAG_CHK;
      S_DIAG_CHK: begin
        if (last_i) begin
          i_d = '0;
          if (zero_q || (mat_rdata == 32'd0)) begin
            status_d = gss_pkg::STATUS_ZERO_PIVOT;
            state_d  = S_EMIT;
          end else begin
            state_d = S_PIV_RD;
          end
        end else begin
          zero_d  = zero_q || (mat_rdata == 32'd0);
          i_d     = i_q + IW'(1);
          state_d = S_DIAG_RD;
        end
      end
      S_PIV_RD: state_d = S_PIV_LD;
      S_PIV_LD: begin
        div_coef_d = 1'b0;
        div_cnt_d  = '0;
        state_d    = S_DIV;
      end
      S_COEF_RD: state_d = S_COEF_LD;
      S_COEF_LD: begin
        div_coef_d = 1'b1;
        div_cnt_d  = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(DW - 1)) begin
          state_d = S_DIV_DONE;
        end
      end
      S_DIV_DONE: begin
        if (!div_coef_q) begin
          j_d     = '0;
          state_d = S_COEF_RD;
        end else if (!last_j) begin
          j_d     = j_q + IW'(1);
          state_d = S_COEF_RD;
        end else if (!last_i) begin
          i_d     = i_q + IW'(1);
          state_d = S_PIV_RD;
        end else begin
          i_d     = '0;
          state_d = S_ROW_INIT;
        end
      end
      S_ROW_INIT: begin
        j_d     = '0;
        state_d = S_TERM_RD;
      end
      S_TERM_RD: begin
        if (!j_is_i) begin
          state_d = S_TERM_MUL;
        end else if (last_j) begin
          state_d = S_ROW_END;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      S_TERM_MUL: state_d = S_TERM_ACC;
      S_TERM_ACC: begin
        if (last_j) begin
          state_d = S_ROW_END;
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_TERM_RD;
        end
      end
      S_ROW_END: begin
        if (diff_abs > {17'd0, tol_q}) begin
          changed_d = 1'b1;
        end
        if (last_i) begin
          state_d = S_SWEEP_END;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_ROW_INIT;
        end
      end
      S_SWEEP_END: begin
        sweep_cnt_d = sweep_cnt_q + 16'd1;
        i_d         = '0;
        if (!changed_q) begin
          status_d = gss_pkg::STATUS_CONVERGED;
          state_d  = S_EMIT;
        end else if (sweep_cnt_d >= limit_eff_q) begin
          status_d = gss_pkg::STATUS_ITER_LIMIT;
          state_d  = S_EMIT;
        end else begin
          changed_d = 1'b0;
          state_d   = S_ROW_INIT;
        end
      end
      S_EMIT: begin
        res_valid_d          = 1'b1;
        res_d.solution_index = 3'(i_q);
        res_d.solution_value = (status_q == gss_pkg::STATUS_ZERO_PIVOT) ? '0 : x_rd;
        res_d.status         = status_q;
        res_d.last           = last_i;
        if (last_i) begin
          state_d = S_IDLE;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= 4'd8;
      tol_q       <= 16'd655;
      limit_q     <= 16'd1000;
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_last_q    <= '0;
      limit_eff_q <= 16'd1;
      sweep_cnt_q <= '0;
      changed_q   <= 1'b0;
      zero_q      <= 1'b0;
      status_q    <= gss_pkg::STATUS_CONVERGED;
      div_coef_q  <= 1'b0;
      div_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gss_pkg::CFG_SYSTEM_SIZE:     size_q  <= cfg_wdata_i[3:0];
          gss_pkg::CFG_TOLERANCE:       tol_q   <= cfg_wdata_i;
          gss_pkg::CFG_ITERATION_LIMIT: limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_last_q    <= n_last_d;
      limit_eff_q <= limit_eff_d;
      sweep_cnt_q <= sweep_cnt_d;
      changed_q   <= changed_d;
      zero_q      <= zero_d;
      status_q    <= status_d;
      div_coef_q  <= div_coef_d;
      div_cnt_q   <= div_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_go && (cmd_i.command == gss_pkg::CMD_LOAD_RHS)
        && (int'(cmd_i.row_index) < MAX_UNKNOWNS)) begin
      rhs_q[IW'(cmd_i.row_index)] <= cmd_i.value;
    end
    if (solve_go) begin
      for (int k = 0; k < MAX_UNKNOWNS; k++) begin
        x_q[k] <= '0;
      end
    end
    if (state_q == S_PIV_LD) begin
      piv_q <= signed'(mat_rdata);
    end
    // Load the divider with magnitudes; keep the sign aside
    if (div_start) begin
      div_neg_q <= div_num[32] ^ div_den_in[31];
      div_quo_q <= {32'(div_num[32] ? -div_num : div_num), FRACTION_BITS'(0)};
      div_den_q <= 32'(div_den_in[31] ? -33'(div_den_in) : 33'(div_den_in));
      div_rem_q <= '0;
    end else if (state_q == S_DIV) begin
      div_rem_q <= rem_ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
      div_quo_q <= {div_quo_q[DW-2:0], rem_ge};
    end
    if ((state_q == S_DIV_DONE) && !div_coef_q) begin
      dvec_q[i_q] <= q_sat;
    end
    if (state_q == S_ROW_INIT) begin
      acc_q <= 64'(dvec_q[i_q]);
    end
    if (state_q == S_TERM_MUL) begin
      prod_q <= signed'(coef_rdata) * x_rd;
    end
    if (state_q == S_TERM_ACC) begin
      acc_q <= acc_q + (prod_q >>> FRACTION_BITS);
    end
    if (state_q == S_ROW_END) begin
      x_q[i_q] <= nx;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `GSS_ASSERT_NXT(a_emit_strobes, state_q == S_EMIT, res_valid_q)
  `GSS_ASSERT_IMP(a_last_goes_idle, res_valid_q && res_q.last, state_q == S_IDLE)
  `GSS_ASSERT_IMP(a_zero_pivot_value, res_valid_q && (res_q.status == gss_pkg::STATUS_ZERO_PIVOT), res_q.solution_value == '0)
  `GSS_ASSERT_IMP(a_sweep_under_cap, state_q == S_ROW_INIT, sweep_cnt_q < limit_eff_q)

endmodule
